@@ sv/dmwbc_pkg.sv @@
`timescale 1ns / 1ps

package dmwbc_pkg;

    // fixed field widths
    localparam int WORD_W         = 32;
    localparam int REQ_ADDR_W     = 16;
    localparam int WORDS_PER_LINE = 4;
    localparam int WORD_SEL_W     = 2;
    localparam int OFFSET_W       = 4;
    localparam int DELAY_W        = 8;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_ENABLED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCESS_DELAY  = 1'b1;

    // command codes
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic capture;
        logic commit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
    } dp_status_t;

endpackage

@@ sv/dmwbc_ctrl.sv @@
`timescale 1ns / 1ps

module dmwbc_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  dmwbc_pkg::dp_status_t status,
    output dmwbc_pkg::dp_cmd_t    cmd
);
    import dmwbc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    // state and output slot registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                // result goes out once the output slot is free or being drained
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output slot occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ sv/dmwbc_datapath.sv @@
`timescale 1ns / 1ps

module dmwbc_datapath
#(
    parameter int NUM_LINES    = 16,
    parameter int ADDRESS_BITS = 16
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  dmwbc_pkg::dp_cmd_t                          cmd,
    output dmwbc_pkg::dp_status_t                       status,
    input  logic                                        cfg_valid,
    input  logic [dmwbc_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [dmwbc_pkg::CFG_DATA_W-1:0]            cfg_data,
    input  logic                                        command,
    input  logic [dmwbc_pkg::REQ_ADDR_W-1:0]            req_address,
    input  logic [dmwbc_pkg::WORD_W-1:0]                write_data,
    input  logic                                        mem_write_accept,
    input  logic                                        mem_read_ready,
    input  logic [dmwbc_pkg::WORD_W-1:0]                fill_word0,
    input  logic [dmwbc_pkg::WORD_W-1:0]                fill_word1,
    input  logic [dmwbc_pkg::WORD_W-1:0]                fill_word2,
    input  logic [dmwbc_pkg::WORD_W-1:0]                fill_word3,
    output logic                                        done_res,
    output logic [dmwbc_pkg::WORD_W-1:0]                read_data,
    output logic                                        hit_pulse,
    output logic                                        miss_pulse,
    output logic                                        writeback_valid,
    output logic [dmwbc_pkg::REQ_ADDR_W-1:0]            writeback_address,
    output logic [dmwbc_pkg::WORD_W-1:0]                victim_word0,
    output logic [dmwbc_pkg::WORD_W-1:0]                victim_word1,
    output logic [dmwbc_pkg::WORD_W-1:0]                victim_word2,
    output logic [dmwbc_pkg::WORD_W-1:0]                victim_word3,
    output logic                                        line_read_valid,
    output logic                                        word_write_valid
);
    import dmwbc_pkg::*;

    // index and tag split; line count is a power of two
    localparam int IDX_W   = $clog2(NUM_LINES);
    localparam int TAG_RAW = REQ_ADDR_W - OFFSET_W - IDX_W;
    localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int PAD_W   = 32 - TAG_W - IDX_W - OFFSET_W;
    localparam logic [REQ_ADDR_W-1:0] ADDR_MASK =
        (ADDRESS_BITS >= REQ_ADDR_W) ? {REQ_ADDR_W{1'b1}}
                                     : REQ_ADDR_W'((32'd1 << ADDRESS_BITS) - 32'd1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LINES - 1);

    typedef logic [WORDS_PER_LINE-1:0][WORD_W-1:0] line_data_t;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
        line_data_t       words;
    } line_row_t;

    // line memory: one row per line with valid, dirty, tag and data
    line_row_t line_mem [NUM_LINES];
    line_row_t row_q_reg;

    // configuration and request tracking
    logic                  enabled_reg;
    logic [DELAY_W-1:0]    delay_reg;
    logic [DELAY_W-1:0]    count_reg;
    logic [DELAY_W-1:0]    count_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic [REQ_ADDR_W-1:0] pend_reg;
    logic [REQ_ADDR_W-1:0] pend_next;
    logic                  lookup_done_reg;
    logic                  lookup_done_next;
    logic [IDX_W-1:0]      clr_idx_reg;

    // captured transaction
    logic                  cmd_reg;
    logic [REQ_ADDR_W-1:0] addr_reg;
    logic [WORD_W-1:0]     wdata_reg;
    logic                  wr_ok_reg;
    logic                  rd_ok_reg;
    line_data_t            fill_reg;

    // result registers
    logic                  done_reg;
    logic                  done_next;
    logic [WORD_W-1:0]     rdata_reg;
    logic [WORD_W-1:0]     rdata_next;
    logic                  hit_reg;
    logic                  hit_next;
    logic                  miss_reg;
    logic                  miss_next;
    logic                  wb_valid_reg;
    logic                  wb_valid_next;
    logic [REQ_ADDR_W-1:0] wb_addr_reg;
    logic [REQ_ADDR_W-1:0] wb_addr_next;
    line_data_t            victim_reg;
    line_data_t            victim_next;
    logic                  lrv_reg;
    logic                  lrv_next;
    logic                  wwv_reg;
    logic                  wwv_next;

    // lookup signals
    logic [REQ_ADDR_W-1:0] in_addr_m;
    logic [IDX_W-1:0]      in_idx;
    logic [REQ_ADDR_W-1:0] addr_m;
    logic [IDX_W-1:0]      idx;
    logic [REQ_ADDR_W-1:0] tag_full;
    logic [TAG_W-1:0]      tag;
    logic [WORD_SEL_W-1:0] wsel;
    logic [31:0]           wb_full;
    logic                  row_we;
    line_row_t             row_wdata;
    logic                  go_count;
    logic                  wb_held;

    // memory write port
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    line_row_t             mem_wdata;

    assign in_addr_m = req_address & ADDR_MASK;
    assign in_idx    = in_addr_m[OFFSET_W +: IDX_W];
    assign addr_m    = addr_reg & ADDR_MASK;
    assign idx       = addr_m[OFFSET_W +: IDX_W];
    assign tag_full  = addr_m >> (OFFSET_W + IDX_W);
    assign tag       = tag_full[TAG_W-1:0];
    assign wsel      = addr_reg[OFFSET_W-1 -: WORD_SEL_W];
    assign wb_full   = {{PAD_W{1'b0}}, row_q_reg.tag, idx, {OFFSET_W{1'b0}}};

    assign status.clear_last = (clr_idx_reg == LAST_IDX);

    // per transaction decision and next state
    always_comb
    begin
        done_next        = 1'b0;
        rdata_next       = '0;
        hit_next         = 1'b0;
        miss_next        = 1'b0;
        wb_valid_next    = 1'b0;
        wb_addr_next     = '0;
        victim_next      = '0;
        lrv_next         = 1'b0;
        wwv_next         = 1'b0;
        busy_next        = busy_reg;
        pend_next        = pend_reg;
        count_next       = count_reg;
        lookup_done_next = lookup_done_reg;
        row_we           = 1'b0;
        row_wdata        = row_q_reg;
        go_count         = 1'b0;
        wb_held          = 1'b0;

        if (!enabled_reg)
        begin
            // uncached pass through
            if (cmd_reg == CMD_WRITE)
            begin
                wwv_next  = 1'b1;
                done_next = wr_ok_reg;
            end
            else
            begin
                lrv_next = 1'b1;
                if (rd_ok_reg)
                begin
                    done_next  = 1'b1;
                    rdata_next = fill_reg[wsel];
                end
            end
        end
        else
        begin
            if (!busy_reg)
            begin
                busy_next = 1'b1;
                pend_next = addr_m;
                go_count  = 1'b1;
            end
            else if (pend_reg != addr_m)
            begin
                // other address refused, empty result
                go_count = 1'b0;
            end
            else if (lookup_done_reg)
            begin
                // miss handling: victim writeback then line fill
                if (row_q_reg.valid && row_q_reg.dirty)
                begin
                    wb_valid_next = 1'b1;
                    wb_addr_next  = REQ_ADDR_W'(wb_full) & ADDR_MASK;
                    victim_next   = row_q_reg.words;
                    if (!wr_ok_reg)
                    begin
                        wb_held = 1'b1;
                    end
                    else
                    begin
                        row_wdata.dirty = 1'b0;
                        row_we          = 1'b1;
                    end
                end
                if (!wb_held)
                begin
                    lrv_next = 1'b1;
                    if (rd_ok_reg)
                    begin
                        row_wdata.words = fill_reg;
                        row_wdata.tag   = tag;
                        row_wdata.valid = 1'b1;
                        if (cmd_reg == CMD_WRITE)
                        begin
                            row_wdata.words[wsel] = wdata_reg;
                            row_wdata.dirty       = 1'b1;
                        end
                        else
                        begin
                            row_wdata.dirty = 1'b0;
                            rdata_next      = fill_reg[wsel];
                        end
                        row_we           = 1'b1;
                        done_next        = 1'b1;
                        busy_next        = 1'b0;
                        pend_next        = '0;
                        count_next       = delay_reg;
                        lookup_done_next = 1'b0;
                    end
                end
            end
            else
            begin
                go_count = 1'b1;
            end

            // access delay countdown and tag check
            if (go_count)
            begin
                count_next = count_reg - DELAY_W'(1);
                if (count_next == '0)
                begin
                    if (row_q_reg.valid && (row_q_reg.tag == tag))
                    begin
                        hit_next  = 1'b1;
                        done_next = 1'b1;
                        if (cmd_reg == CMD_WRITE)
                        begin
                            row_wdata.words[wsel] = wdata_reg;
                            row_wdata.dirty       = 1'b1;
                            row_we                = 1'b1;
                        end
                        else
                        begin
                            rdata_next = row_q_reg.words[wsel];
                        end
                        busy_next        = 1'b0;
                        pend_next        = '0;
                        count_next       = delay_reg;
                        lookup_done_next = 1'b0;
                    end
                    else
                    begin
                        miss_next        = 1'b1;
                        lookup_done_next = 1'b1;
                    end
                end
            end
        end
    end

    // write port select: clearing pass or commit
    always_comb
    begin
        if (cmd.clear)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = cmd.commit && row_we;
            mem_waddr = idx;
            mem_wdata = row_wdata;
        end
    end

    // line memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.capture)
        begin
            row_q_reg <= line_mem[in_idx];
        end
    end

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_idx_reg <= clr_idx_reg + IDX_W'(1);
        end
    end

    // configuration and request state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg     <= 1'b1;
            delay_reg       <= DELAY_W'(1);
            count_reg       <= DELAY_W'(1);
            busy_reg        <= 1'b0;
            pend_reg        <= '0;
            lookup_done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_CACHE_ENABLED:
                    begin
                        enabled_reg <= cfg_data[0];
                    end
                    CFG_ACCESS_DELAY:
                    begin
                        delay_reg <= cfg_data;
                        if (!busy_reg)
                        begin
                            count_reg <= cfg_data;
                        end
                    end
                    default:
                    begin
                        enabled_reg <= enabled_reg;
                    end
                endcase
            end
            if (cmd.commit)
            begin
                busy_reg        <= busy_next;
                pend_reg        <= pend_next;
                count_reg       <= count_next;
                lookup_done_reg <= lookup_done_next;
            end
        end
    end

    // transaction capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg   <= command;
            addr_reg  <= req_address;
            wdata_reg <= write_data;
            wr_ok_reg <= mem_write_accept;
            rd_ok_reg <= mem_read_ready;
            fill_reg  <= {fill_word3, fill_word2, fill_word1, fill_word0};
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            done_reg     <= done_next;
            rdata_reg    <= rdata_next;
            hit_reg      <= hit_next;
            miss_reg     <= miss_next;
            wb_valid_reg <= wb_valid_next;
            wb_addr_reg  <= wb_addr_next;
            victim_reg   <= victim_next;
            lrv_reg      <= lrv_next;
            wwv_reg      <= wwv_next;
        end
    end

    assign done_res          = done_reg;
    assign read_data         = rdata_reg;
    assign hit_pulse         = hit_reg;
    assign miss_pulse        = miss_reg;
    assign writeback_valid   = wb_valid_reg;
    assign writeback_address = wb_addr_reg;
    assign victim_word0      = victim_reg[0];
    assign victim_word1      = victim_reg[1];
    assign victim_word2      = victim_reg[2];
    assign victim_word3      = victim_reg[3];
    assign line_read_valid   = lrv_reg;
    assign word_write_valid  = wwv_reg;

endmodule

@@ sv/direct_mapped_writeback_cache.sv @@
`timescale 1ns / 1ps
// channel   handshake               payload
// in        in_valid / in_stall     command, req_address, write_data, mem_write_accept,
//                                   mem_read_ready, fill_word0..fill_word3
// out       out_valid / out_stall   done_res, read_data, hit_pulse, miss_pulse,
//                                   writeback_valid, writeback_address,
//                                   victim_word0..victim_word3, line_read_valid,
//                                   word_write_valid
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// each transaction: the accept edge reads the line row into a register; in the lookup
// state the block decides, updates the line memory and loads the output register; no new
// transaction is taken until then, as the line memory is read through a register.
// after reset a clearing pass zeroes every row of the line memory with in_stall high.
// a waiting result sits in the output register while the next transaction is taken;
// the decision cycle holds while out_stall keeps that register full.
// NUM_LINES must be a power of two.

module direct_mapped_writeback_cache
#(
    parameter int NUM_LINES    = 16,
    parameter int ADDRESS_BITS = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 command,
    input  logic [dmwbc_pkg::REQ_ADDR_W-1:0]     req_address,
    input  logic [dmwbc_pkg::WORD_W-1:0]         write_data,
    input  logic                                 mem_write_accept,
    input  logic                                 mem_read_ready,
    input  logic [dmwbc_pkg::WORD_W-1:0]         fill_word0,
    input  logic [dmwbc_pkg::WORD_W-1:0]         fill_word1,
    input  logic [dmwbc_pkg::WORD_W-1:0]         fill_word2,
    input  logic [dmwbc_pkg::WORD_W-1:0]         fill_word3,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 done_res,
    output logic [dmwbc_pkg::WORD_W-1:0]         read_data,
    output logic                                 hit_pulse,
    output logic                                 miss_pulse,
    output logic                                 writeback_valid,
    output logic [dmwbc_pkg::REQ_ADDR_W-1:0]     writeback_address,
    output logic [dmwbc_pkg::WORD_W-1:0]         victim_word0,
    output logic [dmwbc_pkg::WORD_W-1:0]         victim_word1,
    output logic [dmwbc_pkg::WORD_W-1:0]         victim_word2,
    output logic [dmwbc_pkg::WORD_W-1:0]         victim_word3,
    output logic                                 line_read_valid,
    output logic                                 word_write_valid,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dmwbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dmwbc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dmwbc_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    // sequencing and handshakes
    dmwbc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    // line storage, request tracking and result registers
    dmwbc_datapath
    #(
        .NUM_LINES    (NUM_LINES),
        .ADDRESS_BITS (ADDRESS_BITS)
    )
    u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (dp_cmd),
        .status            (dp_status),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .command           (command),
        .req_address       (req_address),
        .write_data        (write_data),
        .mem_write_accept  (mem_write_accept),
        .mem_read_ready    (mem_read_ready),
        .fill_word0        (fill_word0),
        .fill_word1        (fill_word1),
        .fill_word2        (fill_word2),
        .fill_word3        (fill_word3),
        .done_res          (done_res),
        .read_data         (read_data),
        .hit_pulse         (hit_pulse),
        .miss_pulse        (miss_pulse),
        .writeback_valid   (writeback_valid),
        .writeback_address (writeback_address),
        .victim_word0      (victim_word0),
        .victim_word1      (victim_word1),
        .victim_word2      (victim_word2),
        .victim_word3      (victim_word3),
        .line_read_valid   (line_read_valid),
        .word_write_valid  (word_write_valid)
    );

endmodule

@@ sv/dmwbc_checker.sv @@
`timescale 1ns / 1ps

module dmwbc_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic                             done_res,
    input logic [dmwbc_pkg::WORD_W-1:0]     read_data,
    input logic                             hit_pulse,
    input logic                             miss_pulse,
    input logic                             writeback_valid,
    input logic                             line_read_valid,
    input logic                             word_write_valid
);
    import dmwbc_pkg::*;

    // a hit always completes the transaction
    a_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit_pulse |-> done_res)
        else $error("hit without completion");

    // a miss only records the lookup, no memory request that cycle
    a_miss_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && miss_pulse |-> !done_res && !line_read_valid && !hit_pulse)
        else $error("miss with completion or line read");

    // victim writeback happens only after the lookup
    a_wb_no_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && writeback_valid |-> !hit_pulse && !miss_pulse && !word_write_valid)
        else $error("writeback in a lookup cycle");

    // uncached word write and line read are exclusive
    a_req_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(line_read_valid && word_write_valid))
        else $error("line read and word write together");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(done_res))
        else $error("stalled result changed");

endmodule

bind direct_mapped_writeback_cache dmwbc_checker u_dmwbc_checker (.*);
